[hdl/lcmlt_pkg.sv]
// Shared types, constants and helpers of the Li Chao max-line tree.
`timescale 1ns / 1ps
package lcmlt_pkg;
	localparam int DOMAIN_BITS = 10;
	localparam int LEVELS      = DOMAIN_BITS + 1;
	localparam int PATH_W      = DOMAIN_BITS;
	localparam int X_W         = 24;
	localparam int COORD_W     = X_W + 2;
	localparam int SLOPE_W     = 32;
	localparam int ICPT_IN_W   = 48;
	localparam int VAL_W       = 61;
	localparam int PROD_W      = SLOPE_W + COORD_W;
	localparam int SUM_W       = VAL_W + 1;
	localparam int CFG_IDX_W   = 1;
	localparam int S_TDATA_W   = 104;
	localparam int M_TDATA_W   = 64;

	localparam logic signed [VAL_W-1:0] EMPTY_VALUE =
		VAL_W'(-64'sd1000000000000000000);
	localparam logic signed [COORD_W-1:0] DOMAIN_SPAN = COORD_W'((1 << DOMAIN_BITS) - 1);
	localparam logic signed [X_W-1:0] X_LOWER_RST = X_W'(0);
	localparam logic signed [X_W-1:0] X_UPPER_RST = X_W'(1023);

	typedef enum logic {OP_INSERT = 1'b0, OP_QUERY = 1'b1} op_t;
	typedef enum logic {REG_X_LOWER = 1'b0, REG_X_UPPER = 1'b1} reg_idx_t;
	typedef enum logic [1:0] {CS_IDLE, CS_PROD, CS_SUM, CS_DECIDE} cell_state_t;

	typedef struct packed {
		logic signed [SLOPE_W-1:0] slope;
		logic signed [VAL_W-1:0]   icpt;
	} node_t;

	typedef struct packed {
		logic                        valid;
		op_t                         op;
		logic                        active;
		node_t                       line;
		logic signed [X_W-1:0]       x;
		logic signed [COORD_W-1:0]   lo;
		logic signed [COORD_W-1:0]   hi;
		logic [PATH_W-1:0]           path;
		logic signed [VAL_W-1:0]     best;
	} token_t;

	typedef struct packed {
		logic              we;
		logic [PATH_W-1:0] addr;
		node_t             wdata;
	} ram_req_t;

	// Level 0 holds one node but keeps a one-bit address.
	function automatic int addr_w(input int level);
		return (level < 1) ? 1 : level;
	endfunction
endpackage

[hdl/li_chao_max_line_tree.sv]
// Top level of the Li Chao max-line tree: config, item entry, level chain, result register.
//
//  channel | direction | handshake          | contents
//  s_*     | in        | s_tvalid/s_tready  | op in tuser; slope, intercept, query_x in tdata
//  m_*     | out       | m_tvalid/m_tready  | max_value in tdata
//  cfg_*   | in        | cfg_valid/cfg_ready| register index and 24-bit value
//
// One item at a time walks a row of DOMAIN_BITS+1 level cells; in each level the
// cell reads its node, forms the products, sums and compares, and writes back on an
// insert. An insert that settles early passes the remaining levels without reading
// or writing their nodes. After reset a clearing pass writes every node of the
// store empty; no item is taken meanwhile.
// One result may wait on m_tready while the next item walks; a second finished
// query holds the input until the first result has left.
`timescale 1ns / 1ps
module li_chao_max_line_tree (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic                               s_tuser,  // op
	// slope [31:0], intercept [79:32], query_x [103:80]
	input  logic [lcmlt_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lcmlt_pkg::M_TDATA_W-1:0]    m_tdata,  // max_value [60:0]
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lcmlt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lcmlt_pkg::X_W-1:0]          cfg_data
);
	import lcmlt_pkg::*;

	logic signed [X_W-1:0] x_lower_q, x_upper_q;
	logic busy_q, res_pend_q, m_tvalid_q, cleaning_q;
	logic [PATH_W-1:0] clr_q;
	logic signed [VAL_W-1:0] res_q, m_data_q;
	token_t head_q;
	token_t chain [LEVELS+1];
	logic accept;
	logic signed [COORD_W-1:0] xl, xu, span_c, upper_eff;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy_q && !cleaning_q;
	assign accept    = s_tvalid && s_tready;

	assign xl     = COORD_W'(x_lower_q);
	assign xu     = COORD_W'(x_upper_q);
	assign span_c = xu - xl;
	always_comb begin
		if (xu < xl) begin
			upper_eff = xl;
		end else if (span_c > DOMAIN_SPAN) begin
			upper_eff = xl + DOMAIN_SPAN;
		end else begin
			upper_eff = xu;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lower_q <= X_LOWER_RST;
			x_upper_q <= X_UPPER_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_X_LOWER: x_lower_q <= cfg_data;
				REG_X_UPPER: x_upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cleaning_q <= 1'b1;
			clr_q      <= '0;
		end else if (cleaning_q) begin
			clr_q <= clr_q + PATH_W'(1);
			if (clr_q == '1) begin
				cleaning_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q.valid     <= accept;
			head_q.op        <= op_t'(s_tuser);
			head_q.active    <= 1'b1;
			head_q.line.slope <= $signed(s_tdata[31:0]);
			head_q.line.icpt <= VAL_W'($signed(s_tdata[79:32]));
			head_q.x         <= $signed(s_tdata[103:80]);
			head_q.lo        <= xl;
			head_q.hi        <= upper_eff;
			head_q.path      <= '0;
			head_q.best      <= EMPTY_VALUE;
		end
	end

	assign chain[0] = head_q;

	for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
		localparam int AW = addr_w(lv);
		ram_req_t req;
		node_t rd, wd;
		logic [$bits(node_t)-1:0] rd_raw;

		assign rd = node_t'(rd_raw);
		always_comb begin
			wd.slope = '0;
			wd.icpt  = EMPTY_VALUE;
			if (!cleaning_q) begin
				wd = req.wdata;
			end
		end

		lcmlt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_tok    (chain[lv]),
			.out_tok   (chain[lv+1]),
			.ram_req   (req),
			.ram_rdata (rd)
		);

		lcmlt_ram #(.AW(AW), .DW($bits(node_t))) u_ram (
			.clk   (clk),
			.we    (cleaning_q || req.we),
			.addr  (cleaning_q ? clr_q[AW-1:0] : req.addr[AW-1:0]),
			.wdata (wd),
			.rdata (rd_raw)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			res_pend_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end
			if (chain[LEVELS].valid) begin
				if (chain[LEVELS].op == OP_QUERY) begin
					res_pend_q <= 1'b1;
				end else begin
					busy_q <= 1'b0;
				end
			end
			if (res_pend_q && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
				res_pend_q <= 1'b0;
				busy_q     <= 1'b0;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain[LEVELS].valid) begin
			res_q <= chain[LEVELS].best;
		end
		if (res_pend_q && (!m_tvalid_q || m_tready)) begin
			m_data_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'($unsigned(m_data_q));
endmodule

[hdl/lcmlt_ram.sv]
// Single-port node memory with registered read data.
`timescale 1ns / 1ps
module lcmlt_ram #(
	parameter int AW = 1,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		rdata_q <= mem[addr];
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;
endmodule

[hdl/lcmlt_cell.sv]
// One tree level: reads its node, compares lines, writes back and hands the item on.
`timescale 1ns / 1ps
module lcmlt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  lcmlt_pkg::token_t in_tok,
	output lcmlt_pkg::token_t out_tok,
	output lcmlt_pkg::ram_req_t ram_req,
	input  lcmlt_pkg::node_t  ram_rdata
);
	import lcmlt_pkg::*;

	cell_state_t state_q, state_d;
	token_t tok_q, tok_n, out_q, out_d;
	node_t st_q;
	logic signed [COORD_W-1:0] mid_q;
	logic signed [PROD_W-1:0] ps_lo_q, ps_hi_q, ps_mid_q, pn_lo_q, pn_hi_q, pn_mid_q;
	logic swap_q, hi_ok_q, mid_win_q, qgt_q;
	logic signed [VAL_W-1:0] qv_q;

	logic signed [COORD_W-1:0] x_ext, p_lo;
	logic signed [SUM_W-1:0] es_lo, es_hi, es_mid, en_lo, en_hi, en_mid;
	logic swap_c;
	node_t low_line, high_line;

	assign x_ext = COORD_W'(tok_q.x);
	// A query evaluates the stored line at x in the slot of the low end.
	assign p_lo  = (tok_q.op == OP_QUERY) ? x_ext : tok_q.lo;

	assign es_lo  = SUM_W'(ps_lo_q)  + SUM_W'(st_q.icpt);
	assign es_hi  = SUM_W'(ps_hi_q)  + SUM_W'(st_q.icpt);
	assign es_mid = SUM_W'(ps_mid_q) + SUM_W'(st_q.icpt);
	assign en_lo  = SUM_W'(pn_lo_q)  + SUM_W'(tok_q.line.icpt);
	assign en_hi  = SUM_W'(pn_hi_q)  + SUM_W'(tok_q.line.icpt);
	assign en_mid = SUM_W'(pn_mid_q) + SUM_W'(tok_q.line.icpt);
	assign swap_c = (es_lo >= en_lo);

	assign low_line  = swap_q ? tok_q.line : st_q;
	assign high_line = swap_q ? st_q : tok_q.line;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (in_tok.valid && in_tok.active) begin
					state_d = CS_PROD;
				end
			end
			CS_PROD:   state_d = CS_SUM;
			CS_SUM:    state_d = CS_DECIDE;
			CS_DECIDE: state_d = CS_IDLE;
			default:   state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		tok_n         = tok_q;
		ram_req.we    = 1'b0;
		ram_req.addr  = (state_q == CS_IDLE) ? in_tok.path : tok_q.path;
		ram_req.wdata = high_line;
		if (tok_q.op == OP_INSERT) begin
			ram_req.we = (state_q == CS_DECIDE);
			if (hi_ok_q) begin
				tok_n.active = 1'b0;
			end else if (mid_win_q) begin
				tok_n.line = low_line;
				tok_n.lo   = mid_q + COORD_W'(1);
				tok_n.path = PATH_W'({tok_q.path, 1'b1});
			end else begin
				ram_req.wdata = low_line;
				tok_n.line    = high_line;
				tok_n.hi      = mid_q;
				tok_n.path    = PATH_W'({tok_q.path, 1'b0});
			end
			if (tok_n.lo > tok_n.hi) begin
				tok_n.active = 1'b0;
			end
		end else begin
			if (qgt_q) begin
				tok_n.best = qv_q;
			end
			if (tok_q.lo >= tok_q.hi) begin
				tok_n.active = 1'b0;
			end else if (x_ext <= mid_q) begin
				tok_n.hi   = mid_q;
				tok_n.path = PATH_W'({tok_q.path, 1'b0});
			end else begin
				tok_n.lo   = mid_q + COORD_W'(1);
				tok_n.path = PATH_W'({tok_q.path, 1'b1});
			end
		end
		if (state_q == CS_DECIDE) begin
			out_d       = tok_n;
			out_d.valid = 1'b1;
		end else begin
			out_d       = in_tok;
			out_d.valid = (state_q == CS_IDLE) && in_tok.valid && !in_tok.active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			out_q   <= '0;
		end else begin
			state_q <= state_d;
			out_q   <= out_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CS_IDLE && in_tok.valid) begin
			tok_q <= in_tok;
			mid_q <= in_tok.lo + ((in_tok.hi - in_tok.lo) >>> 1);
		end
		if (state_q == CS_PROD) begin
			st_q     <= ram_rdata;
			ps_lo_q  <= ram_rdata.slope * p_lo;
			ps_hi_q  <= ram_rdata.slope * tok_q.hi;
			ps_mid_q <= ram_rdata.slope * mid_q;
			pn_lo_q  <= tok_q.line.slope * p_lo;
			pn_hi_q  <= tok_q.line.slope * tok_q.hi;
			pn_mid_q <= tok_q.line.slope * mid_q;
		end
		if (state_q == CS_SUM) begin
			swap_q    <= swap_c;
			hi_ok_q   <= swap_c ? (en_hi <= es_hi) : (es_hi <= en_hi);
			mid_win_q <= swap_c ? (en_mid < es_mid) : (es_mid < en_mid);
			qv_q      <= VAL_W'(es_lo);
			qgt_q     <= (es_lo > SUM_W'(tok_q.best));
		end
	end

	assign out_tok = out_q;
endmodule

[hdl/lcmlt_checker.sv]
// Port-level checks of the Li Chao max-line tree and their binding.
`timescale 1ns / 1ps
module lcmlt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [lcmlt_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);
	// Only one item is in the tree at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in flight");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[63:61] == 3'b000)
		else $error("result padding not zero");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");
endmodule

bind li_chao_max_line_tree lcmlt_checker u_lcmlt_checker (.*);
